// File: hw/rtl/awu_pkg.sv
// Package for the Adam weight update core: configuration indexes, reset
// values, fixed-point constants and the per-item side-band record.
// No dependencies.
package awu_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RATE   = 2'd0,
    CFG_FIRST  = 2'd1,
    CFG_SECOND = 2'd2,
    CFG_GUARD  = 2'd3
  } awu_cfg_e;

  // Reset values of the configuration registers.
  localparam logic [23:0] RateReset   = 24'd16777;
  localparam logic [23:0] FirstReset  = 24'd15099494;
  localparam logic [23:0] SecondReset = 24'd16760438;
  localparam logic [15:0] GuardReset  = 16'd1;

  // Fixed-point layout.
  localparam int unsigned FractionBitsDefault = 24;
  localparam int unsigned CoefBits            = 24;
  localparam int unsigned SquareFraction      = 32;

  // Pipeline depths of the iterative units (two steps per stage).
  localparam int unsigned SqrtStages = 12;
  localparam int unsigned DivStages  = 16;

  // Side-band data that travels with an item through the root and divide stages.
  typedef struct packed {
    logic        frz;
    logic        neg;
    logic [31:0] w;
    logic [31:0] m;
    logic [47:0] v;
  } awu_carry_t;

endpackage

// File: hw/rtl/adam_weight_update_core.sv
// Adam weight update core: fully pipelined fixed-point update of one parameter
// per clock. Depends on awu_pkg.
//
// One item can be started in every clock cycle; busy is never raised. Each item
// produces exactly one result, shown for one cycle with done_o high. It passes
// through the multiply and sum stages in front, the square-root unit (twelve
// stages of two bits) and the divider (sixteen stages of two quotient bits).
// Results cannot be held off by the receiver. Configuration writes are always
// ready and take effect at once; they belong in periods when no item is in
// flight.
module adam_weight_update_core import awu_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FractionBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic signed [31:0] gradient_i,
  input  logic signed [31:0] weight_in_i,
  input  logic signed [31:0] mean_in_i,
  input  logic [47:0]        square_in_i,
  input  logic               frozen_i,
  output logic               done_o,
  output logic signed [31:0] weight_out_o,
  output logic signed [31:0] mean_out_o,
  output logic [47:0]        square_out_o,
  output logic signed [31:0] step_o
);

  // Alignment of the exact square to Q16.32.
  localparam int SqExp   = 2 * int'(FRACTION_BITS) - int'(SquareFraction);
  localparam int SqRight = (SqExp > 0) ? SqExp : 0;
  localparam int SqLeft  = (SqExp < 0) ? -SqExp : 0;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [23:0] rate_q, first_q, second_q;
  logic [15:0] guard_q;
  awu_cfg_e    cfg_sel;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;
  assign cfg_sel     = awu_cfg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RateReset;
      first_q  <= FirstReset;
      second_q <= SecondReset;
      guard_q  <= GuardReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_sel)
        CFG_RATE:   rate_q   <= cfg_data_i;
        CFG_FIRST:  first_q  <= cfg_data_i;
        CFG_SECOND: second_q <= cfg_data_i;
        CFG_GUARD:  guard_q  <= cfg_data_i[15:0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register.
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic signed [31:0] s1_g_q, s1_w_q, s1_m_q;
  logic [47:0]        s1_v_q;
  logic               s1_frz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    s1_g_q   <= gradient_i;
    s1_w_q   <= weight_in_i;
    s1_m_q   <= mean_in_i;
    s1_v_q   <= square_in_i;
    s1_frz_q <= frozen_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gradient square and first moment products.
  // ---------------------------------------------------------------------------
  logic [31:0]        gmag;
  logic [63:0]        g2_d;
  logic signed [24:0] b1_s;
  logic signed [25:0] c1_s;
  logic signed [57:0] pb1m_d, pc1g_d;

  always_comb begin
    gmag   = s1_g_q[31] ? (32'd0 - s1_g_q) : s1_g_q;
    g2_d   = 64'(gmag) * 64'(gmag);
    b1_s   = $signed({1'b0, first_q});
    c1_s   = $signed(26'(1 << CoefBits) - {2'b00, first_q});
    pb1m_d = 58'(b1_s) * 58'(s1_m_q);
    pc1g_d = 58'(c1_s) * 58'(s1_g_q);
  end

  logic               s2_valid_q;
  logic [63:0]        s2_g2_q;
  logic signed [57:0] s2_pb1m_q, s2_pc1g_q;
  logic signed [31:0] s2_w_q, s2_m_q;
  logic [47:0]        s2_v_q;
  logic               s2_frz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else         s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s2_g2_q   <= g2_d;
    s2_pb1m_q <= pb1m_d;
    s2_pc1g_q <= pc1g_d;
    s2_w_q    <= s1_w_q;
    s2_m_q    <= s1_m_q;
    s2_v_q    <= s1_v_q;
    s2_frz_q  <= s1_frz_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: align the square and finish the first moment.
  // ---------------------------------------------------------------------------
  logic [63:0]        g2_shr;
  logic [47:0]        sq_d;
  logic signed [57:0] msum, mshift;
  logic signed [31:0] mn_d;

  always_comb begin
    g2_shr = s2_g2_q >> SqRight;
    if ((g2_shr >> (48 - SqLeft)) != 64'd0) sq_d = '1;
    else                                    sq_d = 48'(g2_shr << SqLeft);
    msum   = s2_pb1m_q + s2_pc1g_q;
    mshift = msum >>> CoefBits;
    if (mshift > 58'sd2147483647)       mn_d = 32'sh7FFFFFFF;
    else if (mshift < -58'sd2147483648) mn_d = 32'sh80000000;
    else                                mn_d = 32'(mshift);
    if (s2_frz_q) mn_d = s2_m_q;
  end

  logic               s3_valid_q;
  logic [47:0]        s3_sq_q, s3_v_q;
  logic signed [31:0] s3_mn_q, s3_w_q;
  logic               s3_frz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else         s3_valid_q <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s3_sq_q  <= sq_d;
    s3_v_q   <= s2_v_q;
    s3_mn_q  <= mn_d;
    s3_w_q   <= s2_w_q;
    s3_frz_q <= s2_frz_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: second moment partial products and the change numerator.
  // ---------------------------------------------------------------------------
  logic [24:0] c2;
  logic [31:0] mmag;
  logic [48:0] pvh_d, pvl_d, psh_d, psl_d;
  logic [55:0] num_d;

  always_comb begin
    c2    = 25'(1 << CoefBits) - {1'b0, second_q};
    pvh_d = 49'(second_q) * 49'(s3_v_q[47:24]);
    pvl_d = 49'(second_q) * 49'(s3_v_q[23:0]);
    psh_d = 49'(c2) * 49'(s3_sq_q[47:24]);
    psl_d = 49'(c2) * 49'(s3_sq_q[23:0]);
    mmag  = s3_mn_q[31] ? (32'd0 - s3_mn_q) : s3_mn_q;
    num_d = 56'(rate_q) * 56'(mmag);
  end

  logic               s4_valid_q;
  logic [48:0]        s4_pvh_q, s4_pvl_q, s4_psh_q, s4_psl_q;
  logic [55:0]        s4_num_q;
  awu_carry_t         s4_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else         s4_valid_q <= s3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s4_pvh_q   <= pvh_d;
    s4_pvl_q   <= pvl_d;
    s4_psh_q   <= psh_d;
    s4_psl_q   <= psl_d;
    s4_num_q   <= num_d;
    s4_c_q.frz <= s3_frz_q;
    s4_c_q.neg <= s3_mn_q[31];
    s4_c_q.w   <= s3_w_q;
    s4_c_q.m   <= s3_mn_q;
    s4_c_q.v   <= s3_v_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sum the second moment; it feeds the square-root pipeline.
  // ---------------------------------------------------------------------------
  logic [49:0] vhi, vlo;
  logic [50:0] vsum;
  logic [47:0] vn_d;
  awu_carry_t  c5_d;

  always_comb begin
    vhi  = 50'(s4_pvh_q) + 50'(s4_psh_q);
    vlo  = 50'(s4_pvl_q) + 50'(s4_psl_q);
    vsum = 51'(vhi) + 51'(vlo >> CoefBits);
    vn_d = (vsum[50:48] != 3'd0) ? '1 : vsum[47:0];
    c5_d = s4_c_q;
    if (!s4_c_q.frz) c5_d.v = vn_d;
  end

  // Square root: two result bits per stage.
  logic        rt_valid_q [SqrtStages+1];
  awu_carry_t  rt_c_q     [SqrtStages+1];
  logic [55:0] rt_num_q   [SqrtStages+1];
  logic [47:0] rt_rad_q   [SqrtStages+1];
  logic [26:0] rt_rem_q   [SqrtStages+1];
  logic [23:0] rt_root_q  [SqrtStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rt_valid_q[0] <= 1'b0;
    else         rt_valid_q[0] <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    rt_c_q[0]    <= c5_d;
    rt_num_q[0]  <= s4_num_q;
    rt_rad_q[0]  <= vn_d;
    rt_rem_q[0]  <= '0;
    rt_root_q[0] <= '0;
  end

  for (genvar k = 0; k < SqrtStages; k++) begin : g_root
    logic [47:0] rad_d;
    logic [26:0] rem_d, rem2, trial;
    logic [23:0] root_d;

    // Restoring square root, two iterations.
    always_comb begin
      rad_d  = rt_rad_q[k];
      rem_d  = rt_rem_q[k];
      root_d = rt_root_q[k];
      rem2   = '0;
      trial  = '0;
      for (int j = 0; j < 2; j++) begin
        rem2  = {rem_d[24:0], rad_d[47:46]};
        trial = {1'b0, root_d, 2'b01};
        rad_d = {rad_d[45:0], 2'b00};
        if (rem2 >= trial) begin
          rem_d  = rem2 - trial;
          root_d = {root_d[22:0], 1'b1};
        end else begin
          rem_d  = rem2;
          root_d = {root_d[22:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rt_valid_q[k+1] <= 1'b0;
      else         rt_valid_q[k+1] <= rt_valid_q[k];
    end

    always_ff @(posedge clk_i) begin
      rt_c_q[k+1]    <= rt_c_q[k];
      rt_num_q[k+1]  <= rt_num_q[k];
      rt_rad_q[k+1]  <= rad_d;
      rt_rem_q[k+1]  <= rem_d;
      rt_root_q[k+1] <= root_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider setup: divisor, overflow test and the initial partial remainder.
  // ---------------------------------------------------------------------------
  logic [24:0] denom, dsafe;
  logic [32:0] dvsr_d;
  logic        ovf_d;

  always_comb begin
    denom  = 25'(rt_root_q[SqrtStages]) + 25'(guard_q);
    // A zero divisor is replaced by one: a nonzero numerator then saturates
    // through the overflow test, and a zero numerator gives a zero quotient.
    dsafe  = (denom == 25'd0) ? 25'd1 : denom;
    dvsr_d = {dsafe, 8'd0};
    // The quotient saturates when it would reach 2^31; a zero numerator is zero.
    ovf_d  = (33'(rt_num_q[SqrtStages][55:31]) >= {denom, 8'd0}) &&
             (rt_num_q[SqrtStages] != 56'd0);
  end

  logic        dv_valid_q [DivStages+1];
  awu_carry_t  dv_c_q     [DivStages+1];
  logic        dv_ovf_q   [DivStages+1];
  logic [32:0] dv_d_q     [DivStages+1];
  logic [32:0] dv_r_q     [DivStages+1];
  logic [31:0] dv_nb_q    [DivStages+1];
  logic [31:0] dv_q_q     [DivStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_valid_q[0] <= 1'b0;
    else         dv_valid_q[0] <= rt_valid_q[SqrtStages];
  end

  always_ff @(posedge clk_i) begin
    dv_c_q[0]   <= rt_c_q[SqrtStages];
    dv_ovf_q[0] <= ovf_d;
    dv_d_q[0]   <= dvsr_d;
    dv_r_q[0]   <= 33'(rt_num_q[SqrtStages][55:32]);
    dv_nb_q[0]  <= rt_num_q[SqrtStages][31:0];
    dv_q_q[0]   <= '0;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [32:0] r_d;
    logic [33:0] r2;
    logic [31:0] nb_d, q_d;

    // Restoring division, two quotient bits.
    always_comb begin
      r_d  = dv_r_q[k];
      nb_d = dv_nb_q[k];
      q_d  = dv_q_q[k];
      r2   = '0;
      for (int j = 0; j < 2; j++) begin
        r2   = {r_d, nb_d[31]};
        nb_d = {nb_d[30:0], 1'b0};
        if (r2 >= {1'b0, dv_d_q[k]}) begin
          r_d = 33'(r2 - {1'b0, dv_d_q[k]});
          q_d = {q_d[30:0], 1'b1};
        end else begin
          r_d = r2[32:0];
          q_d = {q_d[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_valid_q[k+1] <= 1'b0;
      else         dv_valid_q[k+1] <= dv_valid_q[k];
    end

    always_ff @(posedge clk_i) begin
      dv_c_q[k+1]   <= dv_c_q[k];
      dv_ovf_q[k+1] <= dv_ovf_q[k];
      dv_d_q[k+1]   <= dv_d_q[k];
      dv_r_q[k+1]   <= r_d;
      dv_nb_q[k+1]  <= nb_d;
      dv_q_q[k+1]   <= q_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: sign the change and update the weight with saturation.
  // ---------------------------------------------------------------------------
  awu_carry_t         fc;
  logic [31:0]        qmag;
  logic signed [31:0] change_d, wout_d, step_d;
  logic signed [32:0] wsum;

  always_comb begin
    fc   = dv_c_q[DivStages];
    qmag = {1'b0, dv_q_q[DivStages][30:0]};
    if (dv_ovf_q[DivStages]) change_d = fc.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
    else                     change_d = fc.neg ? $signed(32'd0 - qmag) : $signed(qmag);
    wsum = 33'(signed'(fc.w)) + 33'(change_d);
    if (wsum[32] != wsum[31]) wout_d = wsum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else                      wout_d = wsum[31:0];
    step_d = change_d;
    if (fc.frz) begin
      wout_d = fc.w;
      step_d = '0;
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_valid_q[DivStages];
  end

  always_ff @(posedge clk_i) begin
    weight_out_o <= wout_d;
    mean_out_o   <= fc.m;
    square_out_o <= fc.v;
    step_o       <= step_d;
  end

  assign done_o = done_q;

endmodule

// File: verif/adam_weight_update_checker.sv
// Checker for the Adam weight update core: watches the item, result and
// configuration transfers, predicts every result and compares it field by field.
// Depends on awu_pkg.
module adam_weight_update_checker import awu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic signed [31:0] gradient_i,
  input  logic signed [31:0] weight_in_i,
  input  logic signed [31:0] mean_in_i,
  input  logic [47:0]        square_in_i,
  input  logic               frozen_i,
  input  logic               done_o,
  input  logic signed [31:0] weight_out_o,
  input  logic signed [31:0] mean_out_o,
  input  logic [47:0]        square_out_o,
  input  logic signed [31:0] step_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned FracBits = FractionBitsDefault;
  localparam logic [63:0] Mask48 = 64'hFFFF_FFFF_FFFF;
  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] weight;
    logic signed [31:0] mean;
    logic [47:0]        square;
    logic signed [31:0] step;
  } update_t;

  // Shadow copy of the configuration registers.
  logic [23:0] rate_q, first_q, second_q;
  logic [15:0] guard_q;

  update_t updates_due[$];
  int      mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = updates_due.size();

  function automatic longint clip32(longint x);
    if (x > SatMax) return SatMax;
    if (x < SatMin) return SatMin;
    return x;
  endfunction

  // Integer square root, one result bit per iteration.
  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, probe;
    res   = '0;
    probe = 64'd1 << 46;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // Expected outputs of one parameter update under the current registers.
  function automatic update_t adam_update(logic signed [31:0] g, logic signed [31:0] w,
                                          logic signed [31:0] m, logic [47:0] v,
                                          logic frz);
    update_t     u;
    logic [63:0] mag_g, g2, sq, root, denom, mag, num, q;
    logic [127:0] vsum;
    longint      acc, mn, change;
    int          e;
    if (frz) begin
      u.weight = w;
      u.mean   = m;
      u.square = v;
      u.step   = '0;
      return u;
    end
    // Gradient squared, aligned to Q16.32 with saturation.
    mag_g = (g < 0) ? -longint'(g) : longint'(g);
    g2    = mag_g * mag_g;
    e     = 2 * FracBits - SquareFraction;
    if (e >= 0) sq = g2 >> e;
    else if (g2 > (Mask48 >> (-e))) sq = Mask48;
    else sq = g2 << (-e);
    if (sq > Mask48) sq = Mask48;
    // Second moment, exact floor of the weighted sum.
    vsum = 128'(second_q) * 128'(v) + 128'((64'd1 << CoefBits) - second_q) * 128'(sq);
    vsum = vsum >> CoefBits;
    if (vsum > 128'(Mask48)) vsum = 128'(Mask48);
    // First moment, rounded toward minus infinity.
    acc = longint'(first_q) * longint'(m)
        + (longint'(64'd1 << CoefBits) - longint'(first_q)) * longint'(g);
    mn  = clip32(acc >>> CoefBits);
    // Change magnitude, with the zero-divisor case saturating.
    root  = int_root(vsum[63:0]);
    denom = root + guard_q;
    mag   = (mn < 0) ? -mn : mn;
    num   = 64'(rate_q) * mag;
    if (denom == 0) q = (num == 0) ? 64'd0 : 64'h1_0000_0000;
    else q = num / (denom << 8);
    if (mn < 0) change = (q >= 64'h8000_0000) ? SatMin : -longint'(q);
    else change = (q >= 64'h8000_0000) ? SatMax : longint'(q);
    u.weight = clip32(longint'(w) + change);
    u.mean   = mn[31:0];
    u.square = vsum[47:0];
    u.step   = change[31:0];
    return u;
  endfunction

  // Track register writes, queue predictions and check every result.
  always @(posedge clk_i or negedge rst_ni) begin
    update_t exp_u;
    if (!rst_ni) begin
      rate_q   <= RateReset;
      first_q  <= FirstReset;
      second_q <= SecondReset;
      guard_q  <= GuardReset;
      updates_due.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (awu_cfg_e'(cfg_index_i))
          CFG_RATE:   rate_q   <= cfg_data_i;
          CFG_FIRST:  first_q  <= cfg_data_i;
          CFG_SECOND: second_q <= cfg_data_i;
          CFG_GUARD:  guard_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        updates_due.push_back(adam_update(gradient_i, weight_in_i, mean_in_i,
                                          square_in_i, frozen_i));
      end
      if (done_o) begin
        if (updates_due.size() == 0) begin
          if (mismatches < 10) $display("result transfer with no item in flight");
          mismatches <= mismatches + 1;
        end else begin
          exp_u = updates_due.pop_front();
          if (exp_u.weight !== weight_out_o || exp_u.mean !== mean_out_o ||
              exp_u.square !== square_out_o || exp_u.step !== step_o) begin
            if (mismatches < 10) begin
              $display("mismatch: expected w=%h m=%h v=%h step=%h", exp_u.weight,
                       exp_u.mean, exp_u.square, exp_u.step);
              $display("          actual   w=%h m=%h v=%h step=%h", weight_out_o,
                       mean_out_o, square_out_o, step_o);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/adam_weight_update_core_tb.sv
// Testbench top for the Adam weight update core: drives directed and random
// parameter updates through several register settings and gives the verdict.
// Depends on awu_pkg, adam_weight_update_core and adam_weight_update_checker.
module adam_weight_update_core_tb import awu_pkg::*; ();

  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 300000;

  logic               clk_i, rst_ni;
  logic               start, busy;
  logic               cfg_valid_i, cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [23:0]        cfg_data_i;
  logic signed [31:0] gradient_i, weight_in_i, mean_in_i;
  logic [47:0]        square_in_i;
  logic               frozen_i;
  logic               done_o;
  logic signed [31:0] weight_out_o, mean_out_o, step_o;
  logic [47:0]        square_out_o;
  int                 fail_count, pending;
  int                 cycles, updates_sent;

  adam_weight_update_core dut (.*);

  adam_weight_update_checker checker_i (
    .fail_count_o(fail_count), .pending_o(pending), .*
  );

  // Clock and run limit.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[adam_weight_update_core] ERROR");
      $finish;
    end
  end

  // One parameter update; start stays high when the caller sends another.
  task automatic send_update(logic signed [31:0] g, logic signed [31:0] w,
                             logic signed [31:0] m, logic [47:0] v, logic frz);
    gradient_i  <= g;
    weight_in_i <= w;
    mean_in_i   <= m;
    square_in_i <= v;
    frozen_i    <= frz;
    start       <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    updates_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Lets every item in flight come out before the registers change.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write; valid stays high when the caller writes another.
  task automatic write_reg(awu_cfg_e idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [23:0] r, logic [23:0] b1, logic [23:0] b2,
                          logic [15:0] gd);
    write_reg(CFG_RATE, r);
    write_reg(CFG_FIRST, b1);
    write_reg(CFG_SECOND, b2);
    write_reg(CFG_GUARD, {8'd0, gd});
    cfg_valid_i <= 1'b0;
  endtask

  // Mix of extremes, small magnitudes and full-range values.
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $signed($urandom_range(0, 2 << 24)) - (1 << 24);
      3: return $signed($urandom_range(0, 1024)) - 512;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 4))
      0: return '1;
      1: return '0;
      2: return 48'($urandom_range(0, 1 << 20));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  // Random items in bursts with random gaps; some bursts run without gaps.
  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
      end
      send_update(pick32(), pick32(), pick32(), pick48(), $urandom_range(0, 7) == 0);
      burst--;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_RATE;
    cfg_data_i   = '0;
    gradient_i   = '0;
    weight_in_i  = '0;
    mean_in_i    = '0;
    square_in_i  = '0;
    frozen_i     = 1'b0;
    cycles       = 0;
    updates_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: field extremes and frozen pass-through.
    send_update(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, 1'b0);
    send_update(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0, 1'b0);
    send_update('0, '0, '0, '0, 1'b0);
    send_update(32'sh0100_0000, 32'sh0080_0000, -32'sh0040_0000, 48'd12345, 1'b0);
    send_update(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, 1'b1);
    send_update(32'sh1234_5678, -32'sd5, 32'sd77, 48'h8000_0000_0000, 1'b1);
    drain();

    // Large rate, no first decay, full second decay, zero guard:
    // zero divisor both with and without a first moment, saturated weights.
    set_regs('1, '0, '1, '0);
    send_update('0, 32'sd100, '0, '0, 1'b0);
    send_update('0, 32'sd100, 32'sh4000_0000, '0, 1'b0);
    send_update('0, 32'sh8000_0000, 32'sh8000_0000, '0, 1'b0);
    send_update(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, 48'd1, 1'b0);
    send_update(32'sh8000_0000, 32'sh8000_0000, '0, 48'd1, 1'b0);
    send_update(32'sd1, 32'sh7FFF_0000, '0, '0, 1'b0);
    drain();

    // Full first decay, no second decay, largest guard.
    set_regs(24'd1, '1, '0, 16'hFFFF);
    send_update(32'sh7FFF_FFFF, '0, 32'sh7FFF_FFFF, '1, 1'b0);
    send_update(32'sh8000_0000, '0, 32'sh8000_0000, '1, 1'b0);
    send_update(32'sd3, 32'sd3, -32'sd3, 48'd9, 1'b0);
    send_update(-32'sd1, '0, -32'sd1, '0, 1'b0);
    drain();

    // Random phases under the reset settings, then under random and extreme settings.
    set_regs(RateReset, FirstReset, SecondReset, GuardReset);
    random_phase(90);
    for (int p = 0; p < 4; p++) begin
      drain();
      set_regs(pick_coef(), pick_coef(), pick_coef(), 16'($urandom_range(0, 3) == 0 ?
               0 : $urandom));
      random_phase(90);
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d parameter updates over eight register settings,", updates_sent);
    $display("including frozen items, zero divisors and saturated weights");
    if (fail_count == 0) begin
      $display("[adam_weight_update_core] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[adam_weight_update_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/awu_pkg.sv
hw/rtl/adam_weight_update_core.sv
verif/adam_weight_update_checker.sv
verif/adam_weight_update_core_tb.sv
